FILE: sv/edpd_pkg.sv
// package for the error diffusion palette ditherer
// holds command, register and state codes and the diffusion kernel tables
// no dependencies
`default_nettype none

package edpd_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_KERNEL   = 3'd0;
  localparam logic [2:0] REG_SERP     = 3'd1;
  localparam logic [2:0] REG_STRENGTH = 3'd2;
  localparam logic [2:0] REG_LIMIT    = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_COLORS   = 3'd5;

  localparam logic [2:0] KER_FS  = 3'd0;
  localparam logic [2:0] KER_ATK = 3'd1;
  localparam logic [2:0] KER_SL  = 3'd2;
  localparam logic [2:0] KER_STK = 3'd3;
  localparam logic [2:0] KER_JJN = 3'd4;

  localparam int CFG_W = 13;
  localparam int ERR_W = 14;
  localparam int PAL_W = 37;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ERR_RD,
    ST_ERR_WAIT,
    ST_SEARCH,
    ST_QERR,
    ST_RESULT,
    ST_TAP_RD,
    ST_TAP_WR
  } st_t;

  typedef struct packed {
    logic signed [2:0] dx;
    logic [1:0]        dy;
    logic [11:0]       w;
  } tap_t;

  function automatic tap_t mk_tap(input int dx, input int dy, input int w);
    tap_t t;
    t.dx = 3'(dx);
    t.dy = 2'(dy);
    t.w  = 12'(w);
    return t;
  endfunction

  function automatic logic [3:0] tap_count(input logic [2:0] kern);
    case (kern)
      KER_FS:  return 4'd4;
      KER_ATK: return 4'd6;
      KER_SL:  return 4'd3;
      KER_STK: return 4'd12;
      KER_JJN: return 4'd12;
      default: return 4'd0;
    endcase
  endfunction

  // twelve tap layout shared by the two wide kernels
  function automatic tap_t wide_tap(input logic [3:0] i, input logic jjn);
    case (i)
      4'd0:    return mk_tap(1, 0, jjn ? 597 : 780);
      4'd1:    return mk_tap(2, 0, jjn ? 427 : 390);
      4'd2:    return mk_tap(-2, 1, jjn ? 256 : 195);
      4'd3:    return mk_tap(-1, 1, jjn ? 427 : 390);
      4'd4:    return mk_tap(0, 1, jjn ? 597 : 780);
      4'd5:    return mk_tap(1, 1, jjn ? 427 : 390);
      4'd6:    return mk_tap(2, 1, jjn ? 256 : 195);
      4'd7:    return mk_tap(-2, 2, jjn ? 85 : 98);
      4'd8:    return mk_tap(-1, 2, jjn ? 256 : 195);
      4'd9:    return mk_tap(0, 2, jjn ? 427 : 390);
      4'd10:   return mk_tap(1, 2, jjn ? 256 : 195);
      4'd11:   return mk_tap(2, 2, jjn ? 85 : 98);
      default: return mk_tap(0, 0, 0);
    endcase
  endfunction

  function automatic tap_t tap_lookup(input logic [2:0] kern, input logic [3:0] i);
    case (kern)
      KER_FS: begin
        case (i)
          4'd0:    return mk_tap(1, 0, 1792);
          4'd1:    return mk_tap(-1, 1, 768);
          4'd2:    return mk_tap(0, 1, 1280);
          4'd3:    return mk_tap(1, 1, 256);
          default: return mk_tap(0, 0, 0);
        endcase
      end
      KER_ATK: begin
        case (i)
          4'd0:    return mk_tap(1, 0, 512);
          4'd1:    return mk_tap(2, 0, 512);
          4'd2:    return mk_tap(-1, 1, 512);
          4'd3:    return mk_tap(0, 1, 512);
          4'd4:    return mk_tap(1, 1, 512);
          4'd5:    return mk_tap(0, 2, 512);
          default: return mk_tap(0, 0, 0);
        endcase
      end
      KER_SL: begin
        case (i)
          4'd0:    return mk_tap(1, 0, 2048);
          4'd1:    return mk_tap(-1, 1, 1024);
          4'd2:    return mk_tap(0, 1, 1024);
          default: return mk_tap(0, 0, 0);
        endcase
      end
      KER_STK: return wide_tap(i, 1'b0);
      KER_JJN: return wide_tap(i, 1'b1);
      default: return mk_tap(0, 0, 0);
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: sv/edpd_if.sv
// channel interfaces for the error diffusion palette ditherer
// input words carry commands and pixels, output words carry match results
`default_nettype none

interface edpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [12:0]        pixel_l;
  logic signed [11:0] pixel_a;
  logic signed [11:0] pixel_b;
  logic [4:0]         entry_index;
  logic [12:0]        entry_l;
  logic signed [11:0] entry_a;
  logic signed [11:0] entry_b;

  modport source (output valid, cmd, pixel_l, pixel_a, pixel_b, entry_index, entry_l,
                  entry_a, entry_b, input ready);
  modport sink (input valid, cmd, pixel_l, pixel_a, pixel_b, entry_index, entry_l,
                entry_a, entry_b, output ready);
endinterface

interface edpd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  palette_index;
  logic [29:0] distance;
  logic [47:0] frame_error;

  modport source (output valid, palette_index, distance, frame_error, input ready);
  modport sink (input valid, palette_index, distance, frame_error, output ready);
endinterface

`default_nettype wire

FILE: sv/edpd_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module edpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/error_diffusion_palette_dither.sv
// Error diffusion palette ditherer in OKLab Q12: usage notes
//
// Channels: pix takes words (cmd load palette entry, pixel, start frame);
// res gives one word per pixel: palette_index, distance and the running
// frame_error. Registers are written through cfg_write/cfg_index/cfg_data
// by the user only while the block is idle; the block does not enforce it.
// Per pixel: the pixel's stored error is fetched and cleared (ERR_RD,
// ERR_WAIT), the n palette entries in use are swept (one entry per cycle
// through the palette ram), the error is formed (QERR), then the result
// word is loaded (RESULT); the kernel then takes a read and a write state
// per tap that lands in the image and only the read state per dropped tap,
// plus one read state to finish, all through the single port pair of the
// error ram. Loads and unknown commands are taken in idle.
// Reset and every start frame run a clearing pass over all 3 * MAX_WIDTH
// error ram entries with pix.ready low; config writes are still taken.
// A stalled res keeps its word; the next pixel runs up to the result load
// and waits there until the output register is free.
// Depends on edpd_pkg, edpd_if and edpd_ram.
`default_nettype none

module error_diffusion_palette_dither
  import edpd_pkg::*;
#(
  parameter int MAX_COLORS = 32,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  edpd_in_if.sink                pix,
  edpd_out_if.source             res
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int WW     = XW + 1;
  localparam int CIW    = $clog2(MAX_COLORS);
  localparam int CNW    = CIW + 1;
  localparam int EDEPTH = 3 * MAX_WIDTH;
  localparam int EAW    = $clog2(EDEPTH);
  localparam logic [29:0] DIST_MAX = '1;

  function automatic logic signed [21:0] clamp22(input logic signed [21:0] v,
                                                 input logic [12:0] lim);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    hi = $signed({9'b0, lim});
    lo = -hi;
    if (v > hi) return hi;
    else if (v < lo) return lo;
    else return v;
  endfunction

  function automatic logic [EAW-1:0] eaddr(input logic [1:0] s, input logic [XW-1:0] xx);
    return EAW'(32'(s) * MAX_WIDTH + 32'(xx));
  endfunction

  // configuration registers
  logic [2:0]  kernel_sel;
  logic        serp_on;
  logic [9:0]  strength;
  logic [12:0] err_limit;
  logic [10:0] row_width;
  logic [5:0]  colors;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_sel <= KER_FS;
      serp_on    <= 1'b0;
      strength   <= 10'd256;
      err_limit  <= 13'd4096;
      row_width  <= 11'd320;
      colors     <= 6'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL:   kernel_sel <= cfg_data[2:0];
        REG_SERP:     serp_on    <= cfg_data[0];
        REG_STRENGTH: strength   <= cfg_data[9:0];
        REG_LIMIT:    err_limit  <= cfg_data[12:0];
        REG_WIDTH:    row_width  <= cfg_data[10:0];
        REG_COLORS:   colors     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // effective width and color count after range limiting
  logic [WW-1:0]  w_eff;
  logic [CNW-1:0] n_eff;

  always_comb begin
    if (row_width == 11'd0) w_eff = WW'(1);
    else if (32'(row_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(row_width);
    if (colors == 6'd0) n_eff = CNW'(1);
    else if (32'(colors) > MAX_COLORS) n_eff = CNW'(MAX_COLORS);
    else n_eff = CNW'(colors);
  end

  // state
  st_t state, state_next;

  logic [XW-1:0]  column_pos;
  logic [1:0]     row_slot;
  logic           odd_row;
  logic [47:0]    error_total;
  logic [EAW-1:0] clr_addr;

  logic [12:0]        pix_l;
  logic signed [11:0] pix_a, pix_b;
  logic [XW-1:0]      cur_col, cur_x;
  logic [1:0]         cur_slot;
  logic               cur_rev;
  logic signed [16:0] adj_l, adj_a, adj_b;

  // palette sweep pipeline
  logic [CNW-1:0]  rd_idx;
  logic            s1_v, s2_v;
  logic [CIW-1:0]  s1_idx, s2_idx, win_idx;
  logic [31:0]     sq_l, sq_a, sq_b;
  logic [PAL_W-1:0] s2_pal, best_pal;
  logic [33:0]     best_d;
  logic [29:0]     sat_dist;
  logic signed [19:0] qe_l, qe_a, qe_b;

  logic [3:0]         tap_i;
  logic [EAW-1:0]     tap_addr;
  logic signed [20:0] sh_l, sh_a, sh_b;

  // ram ports
  logic             p_we, p_re;
  logic [CIW-1:0]   p_waddr, p_raddr;
  logic [PAL_W-1:0] p_wdata, p_rdata;
  logic             e_we, e_re;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [3*ERR_W-1:0] e_wdata, e_rdata;

  edpd_ram #(.WIDTH(PAL_W), .DEPTH(MAX_COLORS)) u_pal_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  edpd_ram #(.WIDTH(3*ERR_W), .DEPTH(EDEPTH)) u_err_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  wire in_acc = pix.valid && pix.ready;
  wire out_free = !res.valid || res.ready;

  // pixel position for the current word
  logic [WW-1:0] col_fix;
  logic [XW-1:0] x_c;
  logic          rev_c;

  always_comb begin
    col_fix = (WW'(column_pos) >= w_eff) ? (w_eff - WW'(1)) : WW'(column_pos);
    rev_c   = serp_on && odd_row;
    x_c     = rev_c ? XW'(w_eff - WW'(1) - col_fix) : XW'(col_fix);
  end

  // stored error of this pixel, clamped to the current limit
  logic signed [21:0] rd_l, rd_a, rd_b;

  always_comb begin
    rd_l = clamp22(22'($signed(e_rdata[3*ERR_W-1:2*ERR_W])), err_limit);
    rd_a = clamp22(22'($signed(e_rdata[2*ERR_W-1:ERR_W])), err_limit);
    rd_b = clamp22(22'($signed(e_rdata[ERR_W-1:0])), err_limit);
  end

  // distance to the palette entry coming out of the ram
  logic signed [16:0] df_l, df_a, df_b;
  logic signed [33:0] pr_l, pr_a, pr_b;
  logic [33:0]        d_sum;

  always_comb begin
    df_l = adj_l - $signed({4'b0, p_rdata[36:24]});
    df_a = adj_a - 17'($signed(p_rdata[23:12]));
    df_b = adj_b - 17'($signed(p_rdata[11:0]));
    pr_l = df_l * df_l;
    pr_a = df_a * df_a;
    pr_b = df_b * df_b;
    d_sum = 34'(sq_l) + 34'(sq_a) + 34'(sq_b);
  end

  // quantization error against the chosen entry
  logic signed [16:0] qd_l, qd_a, qd_b;
  logic signed [27:0] qp_l, qp_a, qp_b;

  always_comb begin
    qd_l = adj_l - $signed({4'b0, best_pal[36:24]});
    qd_a = adj_a - 17'($signed(best_pal[23:12]));
    qd_b = adj_b - 17'($signed(best_pal[11:0]));
    qp_l = qd_l * $signed({1'b0, strength});
    qp_a = qd_a * $signed({1'b0, strength});
    qp_b = qd_b * $signed({1'b0, strength});
  end

  // current kernel tap, mirrored on reversed rows
  tap_t               tap;
  logic signed [2:0]  tdx;
  logic signed [XW+1:0] nx;
  logic               tap_in;
  logic [2:0]         s_sum;
  logic [1:0]         tap_slot;
  logic signed [32:0] tp_l, tp_a, tp_b;

  always_comb begin
    tap      = tap_lookup(kernel_sel, tap_i);
    tdx      = cur_rev ? -tap.dx : tap.dx;
    nx       = $signed({2'b0, cur_x}) + (XW+2)'(tdx);
    tap_in   = (nx >= 0) && (nx < $signed({1'b0, w_eff}));
    s_sum    = 3'(cur_slot) + 3'(tap.dy);
    tap_slot = (s_sum >= 3'd3) ? 2'(s_sum - 3'd3) : s_sum[1:0];
    tp_l     = qe_l * $signed({1'b0, tap.w});
    tp_a     = qe_a * $signed({1'b0, tap.w});
    tp_b     = qe_b * $signed({1'b0, tap.w});
  end

  // read, add the share, clamp and write back
  logic signed [21:0] nw_l, nw_a, nw_b;

  always_comb begin
    nw_l = clamp22(22'($signed(e_rdata[3*ERR_W-1:2*ERR_W])) + 22'(sh_l), err_limit);
    nw_a = clamp22(22'($signed(e_rdata[2*ERR_W-1:ERR_W])) + 22'(sh_a), err_limit);
    nw_b = clamp22(22'($signed(e_rdata[ERR_W-1:0])) + 22'(sh_b), err_limit);
  end

  logic [48:0] tot_sum;
  assign tot_sum = {1'b0, error_total} + 49'(sat_dist);

  // next state and ram controls
  always_comb begin
    state_next = state;
    pix.ready  = 1'b0;
    p_we    = 1'b0;
    p_waddr = CIW'(pix.entry_index);
    p_wdata = {pix.entry_l, pix.entry_a, pix.entry_b};
    p_re    = 1'b0;
    p_raddr = rd_idx[CIW-1:0];
    e_we    = 1'b0;
    e_waddr = clr_addr;
    e_wdata = '0;
    e_re    = 1'b0;
    e_raddr = eaddr(row_slot, x_c);
    case (state)
      ST_IDLE: begin
        pix.ready = 1'b1;
        if (pix.valid) begin
          case (pix.cmd)
            CMD_LOAD:  p_we = 32'(pix.entry_index) < MAX_COLORS;
            CMD_PIXEL: state_next = ST_ERR_RD;
            CMD_START: state_next = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        e_we = 1'b1;
        if (clr_addr == EAW'(EDEPTH - 1)) state_next = ST_IDLE;
      end
      ST_ERR_RD: begin
        e_re = 1'b1;
        state_next = ST_ERR_WAIT;
      end
      ST_ERR_WAIT: begin
        // entry is consumed: write it back as zero
        e_we    = 1'b1;
        e_waddr = eaddr(cur_slot, cur_x);
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        p_re = rd_idx < n_eff;
        if (rd_idx == n_eff && !s1_v && !s2_v) state_next = ST_QERR;
      end
      ST_QERR: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_next = ST_TAP_RD;
      end
      ST_TAP_RD: begin
        e_raddr = eaddr(tap_slot, XW'(nx));
        if (tap_i >= tap_count(kernel_sel)) begin
          state_next = ST_IDLE;
        end else if (tap_in) begin
          e_re = 1'b1;
          state_next = ST_TAP_WR;
        end
      end
      ST_TAP_WR: begin
        e_we    = 1'b1;
        e_waddr = tap_addr;
        e_wdata = {nw_l[ERR_W-1:0], nw_a[ERR_W-1:0], nw_b[ERR_W-1:0]};
        state_next = ST_TAP_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // frame and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos  <= '0;
      row_slot    <= '0;
      odd_row     <= 1'b0;
      error_total <= '0;
      clr_addr    <= '0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      rd_idx      <= '0;
      tap_i       <= '0;
      res.valid   <= 1'b0;
    end else begin
      // load a new word or drop the one just taken
      if (state == ST_RESULT && out_free) res.valid <= 1'b1;
      else if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc && pix.cmd == CMD_START) begin
            column_pos  <= '0;
            row_slot    <= '0;
            odd_row     <= 1'b0;
            error_total <= '0;
            clr_addr    <= '0;
          end
        end
        ST_CLEAR: clr_addr <= clr_addr + EAW'(1);
        ST_ERR_WAIT: begin
          rd_idx <= '0;
          s1_v   <= 1'b0;
          s2_v   <= 1'b0;
        end
        ST_SEARCH: begin
          s1_v <= rd_idx < n_eff;
          s2_v <= s1_v;
          if (rd_idx < n_eff) rd_idx <= rd_idx + CNW'(1);
        end
        ST_RESULT: begin
          if (out_free) begin
            error_total <= tot_sum[48] ? '1 : tot_sum[47:0];
            tap_i       <= '0;
            // advance along the row, wrap to the next ring slot at its end
            if (WW'(cur_col) + WW'(1) >= w_eff) begin
              column_pos <= '0;
              row_slot   <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
              odd_row    <= !odd_row;
            end else begin
              column_pos <= cur_col + XW'(1);
            end
          end
        end
        ST_TAP_RD: begin
          if (tap_i < tap_count(kernel_sel) && !tap_in) tap_i <= tap_i + 4'd1;
        end
        ST_TAP_WR: tap_i <= tap_i + 4'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pix_l <= pix.pixel_l;
        pix_a <= pix.pixel_a;
        pix_b <= pix.pixel_b;
      end
      ST_ERR_RD: begin
        cur_col  <= XW'(col_fix);
        cur_x    <= x_c;
        cur_slot <= row_slot;
        cur_rev  <= rev_c;
      end
      ST_ERR_WAIT: begin
        adj_l <= $signed({4'b0, pix_l}) + $signed(rd_l[16:0]);
        adj_a <= 17'(pix_a) + $signed(rd_a[16:0]);
        adj_b <= 17'(pix_b) + $signed(rd_b[16:0]);
      end
      ST_SEARCH: begin
        s1_idx <= rd_idx[CIW-1:0];
        sq_l   <= pr_l[31:0];
        sq_a   <= pr_a[31:0];
        sq_b   <= pr_b[31:0];
        s2_idx <= s1_idx;
        s2_pal <= p_rdata;
        // strict less keeps the lowest index on a tie
        if (s2_v && (s2_idx == '0 || d_sum < best_d)) begin
          best_d   <= d_sum;
          win_idx  <= s2_idx;
          best_pal <= s2_pal;
        end
      end
      ST_QERR: begin
        sat_dist <= (best_d > 34'(DIST_MAX)) ? DIST_MAX : best_d[29:0];
        qe_l <= qp_l[27:8];
        qe_a <= qp_a[27:8];
        qe_b <= qp_b[27:8];
      end
      ST_RESULT: begin
        if (out_free) begin
          res.palette_index <= 5'(win_idx);
          res.distance      <= sat_dist;
          res.frame_error   <= tot_sum[48] ? '1 : tot_sum[47:0];
        end
      end
      ST_TAP_RD: begin
        tap_addr <= eaddr(tap_slot, XW'(nx));
        sh_l     <= tp_l[32:12];
        sh_a     <= tp_a[32:12];
        sh_b     <= tp_b[32:12];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/edpd_checker.sv
// port level checks for the error diffusion palette ditherer
// depends on edpd_pkg; bound to the top level below
`default_nettype none

module edpd_checker
  import edpd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  out_index,
  input wire logic [29:0] out_distance,
  input wire logic [47:0] out_frame_error
);

  // clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_START |=> !in_ready)
    else $error("start frame did not begin clearing");

  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_PIXEL |=> !in_ready)
    else $error("pixel word did not hold off the input");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) &&
    $stable(out_distance) && $stable(out_frame_error))
    else $error("stalled result word changed");

endmodule

bind error_diffusion_palette_dither edpd_checker u_edpd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(pix.valid),
  .in_ready(pix.ready),
  .in_cmd(pix.cmd),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .out_index(res.palette_index),
  .out_distance(res.distance),
  .out_frame_error(res.frame_error)
);

`default_nettype wire

FILE: verif/edpd_match_checker.sv
// checker for the error diffusion palette ditherer: predicts and compares result words
// depends on edpd_pkg and the edpd_in_if / edpd_out_if channel interfaces
`timescale 1ns / 1ps

module edpd_match_checker
  import edpd_pkg::*;
#(
  parameter int MAX_COLORS = 32,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  edpd_in_if               pix,
  edpd_out_if              res,
  output int               mismatches,
  output int               outstanding
);

  localparam longint unsigned DIST_SAT  = 64'd1073741823;
  localparam longint unsigned TOTAL_SAT = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [4:0]  idx;
    logic [29:0] near_d;
    logic [47:0] total;
  } match_t;

  localparam int tap_n [5] = '{4, 6, 3, 12, 12};
  localparam int tap_dx [5][12] = '{
    '{1, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 2, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 2, -2, -1, 0, 1, 2, -2, -1, 0, 1, 2},
    '{1, 2, -2, -1, 0, 1, 2, -2, -1, 0, 1, 2}};
  localparam int tap_dy [5][12] = '{
    '{0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 1, 1, 2, 0, 0, 0, 0, 0, 0},
    '{0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2},
    '{0, 0, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2}};
  localparam int tap_w [5][12] = '{
    '{1792, 768, 1280, 256, 0, 0, 0, 0, 0, 0, 0, 0},
    '{512, 512, 512, 512, 512, 512, 0, 0, 0, 0, 0, 0},
    '{2048, 1024, 1024, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{780, 390, 195, 390, 780, 390, 195, 98, 195, 390, 195, 98},
    '{597, 427, 256, 427, 597, 427, 256, 85, 256, 427, 256, 85}};

  logic [2:0]  kern_sel;
  logic        serp_on;
  logic [9:0]  strength;
  logic [12:0] err_lim;
  logic [10:0] width_reg;
  logic [5:0]  colors_reg;

  int              pal [MAX_COLORS][3];
  int              err_store [3][MAX_WIDTH][3];
  int              col_pos, ring_slot;
  bit              odd_line;
  longint unsigned run_total;
  match_t          match_q[$];

  function automatic longint clampv(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic clear_frame();
    for (int s = 0; s < 3; s++)
      for (int x = 0; x < MAX_WIDTH; x++)
        for (int c = 0; c < 3; c++) err_store[s][x][c] = 0;
    col_pos = 0;
    ring_slot = 0;
    odd_line = 0;
    run_total = 0;
  endtask

  task automatic match_pixel(input logic [12:0] l, input logic signed [11:0] a,
                             input logic signed [11:0] b);
    int              w, n, x, best, nx, s, dx;
    bit              rev;
    longint          lim, adj[3], qe[3], df, share;
    longint unsigned d, best_d, sat_d;
    match_t          m;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    n = colors_reg;
    if (n < 1) n = 1;
    if (n > MAX_COLORS) n = MAX_COLORS;
    if (col_pos >= w) col_pos = w - 1;
    rev = serp_on && odd_line;
    x = rev ? (w - 1 - col_pos) : col_pos;
    lim = err_lim;
    adj[0] = l;
    adj[1] = a;
    adj[2] = b;
    for (int c = 0; c < 3; c++) begin
      adj[c] += clampv(err_store[ring_slot][x][c], lim);
      err_store[ring_slot][x][c] = 0;
    end
    best = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        df = adj[c] - pal[i][c];
        d += longint'(df * df);
      end
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    sat_d = (best_d > DIST_SAT) ? DIST_SAT : best_d;
    run_total = (TOTAL_SAT - run_total < sat_d) ? TOTAL_SAT : run_total + sat_d;
    for (int c = 0; c < 3; c++)
      qe[c] = ((adj[c] - pal[best][c]) * longint'(strength)) >>> 8;
    // unknown kernels spread nothing
    if (kern_sel <= KER_JJN) begin
      for (int t = 0; t < tap_n[kern_sel]; t++) begin
        dx = rev ? -tap_dx[kern_sel][t] : tap_dx[kern_sel][t];
        nx = x + dx;
        s = (ring_slot + tap_dy[kern_sel][t]) % 3;
        if (nx < 0 || nx >= w) continue;
        for (int c = 0; c < 3; c++) begin
          share = (qe[c] * tap_w[kern_sel][t]) >>> 12;
          err_store[s][nx][c] = int'(clampv(err_store[s][nx][c] + share, lim));
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      ring_slot = (ring_slot + 1) % 3;
      odd_line = !odd_line;
    end
    m.idx = best[4:0];
    m.near_d = sat_d[29:0];
    m.total = run_total[47:0];
    match_q.push_back(m);
  endtask

  always @(posedge clk) begin
    match_t m;
    if (rst) begin
      kern_sel = KER_FS;
      serp_on = 0;
      strength = 10'd256;
      err_lim = 13'd4096;
      width_reg = 11'd320;
      colors_reg = 6'd32;
      for (int i = 0; i < MAX_COLORS; i++)
        for (int c = 0; c < 3; c++) pal[i][c] = 0;
      clear_frame();
      match_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_KERNEL:   kern_sel = cfg_data[2:0];
          REG_SERP:     serp_on = cfg_data[0];
          REG_STRENGTH: strength = cfg_data[9:0];
          REG_LIMIT:    err_lim = cfg_data[12:0];
          REG_WIDTH:    width_reg = cfg_data[10:0];
          REG_COLORS:   colors_reg = cfg_data[5:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        case (cmd_t'(pix.cmd))
          CMD_LOAD: begin
            if (pix.entry_index < MAX_COLORS) begin
              pal[pix.entry_index][0] = pix.entry_l;
              pal[pix.entry_index][1] = pix.entry_a;
              pal[pix.entry_index][2] = pix.entry_b;
            end
          end
          CMD_PIXEL: match_pixel(pix.pixel_l, pix.pixel_a, pix.pixel_b);
          CMD_START: clear_frame();
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result word idx %0d dist %0d total %0d", $time,
                   res.palette_index, res.distance, res.frame_error);
          mismatches <= mismatches + 1;
        end else begin
          m = match_q.pop_front();
          if (m.idx !== res.palette_index || m.near_d !== res.distance ||
              m.total !== res.frame_error) begin
            $display("%0t: expected idx %0d dist %0d total %0d, got idx %0d dist %0d total %0d",
                     $time, m.idx, m.near_d, m.total, res.palette_index, res.distance,
                     res.frame_error);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= match_q.size();
  end

endmodule

FILE: verif/error_diffusion_palette_dither_tb.sv
// top of the error diffusion palette ditherer testbench: clock, reset, stimulus, verdict
// depends on edpd_pkg, the channel interfaces, the block and edpd_match_checker
`timescale 1ns / 1ps

module error_diffusion_palette_dither_tb;
  import edpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_write;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               mismatches, outstanding;
  int               snd_idle_pct, rcv_idle_pct;
  int               quiet_cycles;

  edpd_in_if  pix_if ();
  edpd_out_if res_if ();

  error_diffusion_palette_dither i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix_if.sink), .res(res_if.source)
  );

  edpd_match_checker i_match_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix_if), .res(res_if),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // receiver side: random back pressure on the result channel
  initial res_if.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // watchdog: covers the clearing pass after a start frame plus long stalls
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic cfg_put(input logic [2:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
  endtask

  task automatic configure(input int kern, input int serp, input int str, input int lim,
                           input int wid, input int ncol);
    cfg_put(REG_KERNEL, kern);
    cfg_put(REG_SERP, serp);
    cfg_put(REG_STRENGTH, str);
    cfg_put(REG_LIMIT, lim);
    cfg_put(REG_WIDTH, wid);
    cfg_put(REG_COLORS, ncol);
    cfg_write <= 1'b0;
  endtask

  // hold one word on the pix channel until the block takes it
  task automatic send_word(input cmd_t c, input logic [12:0] l, input logic [11:0] a,
                           input logic [11:0] b, input logic [4:0] idx);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.cmd         <= c;
    pix_if.pixel_l     <= l;
    pix_if.pixel_a     <= a;
    pix_if.pixel_b     <= b;
    pix_if.entry_index <= idx;
    pix_if.entry_l     <= l;
    pix_if.entry_a     <= a;
    pix_if.entry_b     <= b;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  function automatic bit i_match_checker_busy();
    return res_if.valid;
  endfunction

  // drain results, then let the kernel writes of the last pixel finish
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || i_match_checker_busy()) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [12:0] rand_l();
    // mostly the nominal range, sometimes the full 13 bits
    return ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                       : 13'($urandom_range(0, 4096));
  endfunction

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85)
      send_word(CMD_PIXEL, rand_l(), 12'($urandom), 12'($urandom), 5'($urandom));
    else if (pick < 92)
      send_word(CMD_LOAD, rand_l(), 12'($urandom), 12'($urandom), 5'($urandom));
    else if (pick < 95)
      send_word(CMD_START, rand_l(), 12'($urandom), 12'($urandom), 5'($urandom));
    else
      send_word(CMD_NONE, rand_l(), 12'($urandom), 12'($urandom), 5'($urandom));
  endtask

  initial begin
    int wid, str, lim, ncol;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.cmd = CMD_NONE;
    pix_if.pixel_l = '0;
    pix_if.pixel_a = '0;
    pix_if.pixel_b = '0;
    pix_if.entry_index = '0;
    pix_if.entry_l = '0;
    pix_if.entry_a = '0;
    pix_if.entry_b = '0;
    snd_idle_pct = 21;
    rcv_idle_pct = 79;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every palette slot gets written before any pixel reads one
    configure(KER_FS, 0, 256, 4096, 4, 32);
    for (int i = 0; i < 32; i++)
      send_word(CMD_LOAD, rand_l(), 12'($urandom), 12'($urandom), 5'(i));
    send_word(CMD_LOAD, 13'd0, 12'h800, 12'h800, 5'd0);
    send_word(CMD_LOAD, 13'd4096, 12'h7FF, 12'h7FF, 5'd31);
    send_word(CMD_LOAD, 13'd8191, 12'h000, 12'hFFF, 5'd17);
    // field extremes, a tie-prone mid gray, then an ignored command
    send_word(CMD_PIXEL, 13'd0, 12'h800, 12'h800, 5'd0);
    send_word(CMD_PIXEL, 13'd4096, 12'h7FF, 12'h7FF, 5'd0);
    send_word(CMD_PIXEL, 13'd8191, 12'h7FF, 12'h800, 5'd0);
    send_word(CMD_PIXEL, 13'd2048, 12'h000, 12'h000, 5'd0);
    send_word(CMD_NONE, 13'd1234, 12'h123, 12'h321, 5'd3);
    send_word(CMD_PIXEL, 13'd8191, 12'h800, 12'h7FF, 5'd0);
    // start frame drops error left below the last row
    send_word(CMD_START, 13'd0, 12'h000, 12'h000, 5'd0);
    send_word(CMD_PIXEL, 13'd100, 12'h010, 12'hFF0, 5'd0);
    send_word(CMD_PIXEL, 13'd4000, 12'h700, 12'h900, 5'd0);
    settle();

    // random phases: register extremes, width shrunk mid row, unknown kernels
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        snd_idle_pct = 79;
        rcv_idle_pct = 21;
      end else if (ph == 8) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (ph % 4)
        0: str = 0;
        1: str = 512;
        2: str = 1023;
        default: str = $urandom_range(0, 1023);
      endcase
      case (ph % 3)
        0: lim = 4096;
        1: lim = (ph < 6) ? 0 : 8191;
        default: lim = $urandom_range(0, 8191);
      endcase
      case (ph)
        5: wid = 0;
        7: wid = 2047;
        9: wid = 1024;
        default: wid = $urandom_range(1, 16);
      endcase
      case (ph % 5)
        0: ncol = 1;
        1: ncol = 32;
        2: ncol = 63;
        3: ncol = 0;
        default: ncol = $urandom_range(1, 63);
      endcase
      configure(ph % 8, $urandom_range(0, 1), str, lim, wid, ncol);
      if ($urandom_range(0, 1)) send_word(CMD_START, 13'd0, '0, '0, '0);
      for (int k = 0; k < 67; k++) random_word();
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: error_diffusion_palette_dither.f
sv/edpd_pkg.sv
sv/edpd_if.sv
sv/edpd_ram.sv
sv/error_diffusion_palette_dither.sv
sv/edpd_checker.sv
verif/edpd_match_checker.sv
verif/error_diffusion_palette_dither_tb.sv
